// ----- hdl/traffic_signal_sequencer_macros.svh -----
// Assertion macros shared by the traffic signal sequencer checkers.
`ifndef TRAFFIC_SIGNAL_SEQUENCER_MACROS_SVH
`define TRAFFIC_SIGNAL_SEQUENCER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TSS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/tss_pkg.sv -----
// Types, constants and lookup tables of the traffic signal sequencer.
package tss_pkg;

   localparam int NUM_PHASES = 43;
   localparam int NUM_REGS   = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int PHASE_W    = 6;
   localparam int TICKS_W    = 16;
   localparam int IN_W       = 8;
   localparam int OUT_W      = 40;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_COMMON = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DAY1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DAY2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BUSY1  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BUSY2  = 3'd4;

   // Slots of the common timing register
   localparam logic [1:0] SLOT_YELLOW    = 2'd0;
   localparam logic [1:0] SLOT_ALL_RED   = 2'd1;
   localparam logic [1:0] SLOT_FLASH_ON  = 2'd2;
   localparam logic [1:0] SLOT_FLASH_OFF = 2'd3;

   // Phases with special sequencing
   localparam logic [PHASE_W-1:0] PH_NS_GREEN        = 6'd0;
   localparam logic [PHASE_W-1:0] PH_DAY_CLEAR_NS    = 6'd2;
   localparam logic [PHASE_W-1:0] PH_NORTH_LEFT      = 6'd3;
   localparam logic [PHASE_W-1:0] PH_DAY_CLEAR_NL    = 6'd5;
   localparam logic [PHASE_W-1:0] PH_SOUTH_LEFT      = 6'd6;
   localparam logic [PHASE_W-1:0] PH_DAY_CLEAR_SL    = 6'd8;
   localparam logic [PHASE_W-1:0] PH_WEST_GREEN      = 6'd9;
   localparam logic [PHASE_W-1:0] PH_DAY_LAST        = 6'd17;
   localparam logic [PHASE_W-1:0] PH_RESET           = 6'd18;
   localparam logic [PHASE_W-1:0] PH_BUSY_START      = 6'd19;
   localparam logic [PHASE_W-1:0] PH_NORTH_SOLO      = 6'd20;
   localparam logic [PHASE_W-1:0] PH_SOUTH_LEFT_BUSY = 6'd21;
   localparam logic [PHASE_W-1:0] PH_BOTH_GREEN      = 6'd22;
   localparam logic [PHASE_W-1:0] PH_NORTH_LEFT_BUSY = 6'd23;
   localparam logic [PHASE_W-1:0] PH_BOTH_YELLOW     = 6'd24;
   localparam logic [PHASE_W-1:0] PH_BUSY_LAST       = 6'd35;
   localparam logic [PHASE_W-1:0] PH_FLASH_ON        = 6'd38;
   localparam logic [PHASE_W-1:0] PH_FLASH_OFF       = 6'd39;
   localparam logic [PHASE_W-1:0] PH_EMERGENCY       = 6'd42;

   typedef enum logic [1:0] {
      MODE_DAY   = 2'd0,
      MODE_BUSY  = 2'd1,
      MODE_FLASH = 2'd2,
      MODE_EMERG = 2'd3
   } mode_type;

   // One tick as it travels from the input register to the sequencer
   typedef struct packed {
      logic     valid;
      mode_type mode;
      logic     north;
      logic     south;
   } tick_type;

   // Sequencer result for one tick
   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               changed;
   } status_type;

   typedef struct packed {
      logic [6:0] north;
      logic [9:0] south;
      logic [6:0] west;
      logic [5:0] east;
   } lamps_type;

   // Where a phase takes its duration from
   typedef struct packed {
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [1:0]           slot;
   } dur_sel_type;

   typedef logic [NUM_REGS-1:0][CSR_DATA_W-1:0] cfg_type;

   localparam logic [6:0] AR_N = 7'd9;
   localparam logic [9:0] AR_S = 10'd73;
   localparam logic [6:0] AR_W = 7'd9;
   localparam logic [5:0] AR_E = 6'd9;

   localparam lamps_type LAMPS_ALL_RED = '{AR_N, AR_S, AR_W, AR_E};

   localparam lamps_type LAMP_TABLE [NUM_PHASES] = '{
      '{7'd36, 10'd292, AR_W, AR_E},   // NS green
      '{7'd18, 10'd146, AR_W, AR_E},   // NS yellow
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{7'd73, AR_S,    AR_W, AR_E},   // north left green
      '{7'd10, AR_S,    AR_W, AR_E},   // north left yellow
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{AR_N,  10'd585, AR_W, AR_E},   // south left green
      '{AR_N,  10'd74,  AR_W, AR_E},   // south left yellow
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{AR_N,  AR_S,    7'd36, AR_E},  // west through green
      '{AR_N,  AR_S,    7'd18, AR_E},  // west through yellow
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{AR_N,  AR_S,    AR_W, 6'd36},  // east through green
      '{AR_N,  AR_S,    AR_W, 6'd18},  // east through yellow
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{AR_N,  AR_S,    7'd65, AR_E},  // west right arrow
      '{AR_N,  AR_S,    7'd17, AR_E},  // west right yellow
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{7'd36, AR_S,    AR_W, AR_E},   // north solo green
      '{7'd36, 10'd585, AR_W, AR_E},   // south left during north
      '{7'd36, 10'd292, AR_W, AR_E},   // both green
      '{7'd73, 10'd292, AR_W, AR_E},   // north left during south
      '{7'd18, 10'd146, AR_W, AR_E},   // both yellow
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{AR_N,  AR_S,    7'd36, AR_E},
      '{AR_N,  AR_S,    7'd18, AR_E},
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{AR_N,  AR_S,    AR_W, 6'd36},
      '{AR_N,  AR_S,    AR_W, 6'd18},
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{AR_N,  AR_S,    7'd65, AR_E},
      '{AR_N,  AR_S,    7'd17, AR_E},
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{7'd18, 10'd18,  AR_W, AR_E},   // night flash on
      '{7'd0,  10'd0,   7'd0, 6'd0},   // night flash off
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{AR_N,  AR_S,    AR_W, AR_E},
      '{AR_N,  AR_S,    AR_W, AR_E}    // emergency hold
   };

   localparam dur_sel_type DUR_ALL_RED = '{REG_COMMON, SLOT_ALL_RED};
   localparam dur_sel_type DUR_YELLOW  = '{REG_COMMON, SLOT_YELLOW};

   localparam dur_sel_type DUR_TABLE [NUM_PHASES] = '{
      '{REG_DAY1, 2'd0}, DUR_YELLOW, DUR_ALL_RED,
      '{REG_DAY1, 2'd1}, DUR_YELLOW, DUR_ALL_RED,
      '{REG_DAY1, 2'd2}, DUR_YELLOW, DUR_ALL_RED,
      '{REG_DAY1, 2'd3}, DUR_YELLOW, DUR_ALL_RED,
      '{REG_DAY2, 2'd0}, DUR_YELLOW, DUR_ALL_RED,
      '{REG_DAY2, 2'd1}, DUR_YELLOW, DUR_ALL_RED,
      DUR_ALL_RED, DUR_ALL_RED,
      '{REG_BUSY1, 2'd0}, '{REG_BUSY1, 2'd1}, '{REG_BUSY1, 2'd2}, '{REG_BUSY1, 2'd3},
      DUR_YELLOW, DUR_ALL_RED,
      '{REG_BUSY2, 2'd0}, DUR_YELLOW, DUR_ALL_RED,
      '{REG_BUSY2, 2'd1}, DUR_YELLOW, DUR_ALL_RED,
      '{REG_BUSY2, 2'd2}, DUR_YELLOW, DUR_ALL_RED,
      DUR_ALL_RED, DUR_ALL_RED, DUR_ALL_RED,
      '{REG_COMMON, SLOT_FLASH_ON}, '{REG_COMMON, SLOT_FLASH_OFF},
      DUR_ALL_RED, DUR_ALL_RED,
      '{REG_DAY2, 2'd2}
   };

endpackage

// ----- hdl/tss_csr.sv -----
// Timing register file of the traffic signal sequencer.
module tss_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [tss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tss_pkg::CSR_DATA_W-1:0]   csr_data,
   output tss_pkg::cfg_type                 cfg
);

   tss_pkg::cfg_type regs_ff;
   tss_pkg::cfg_type regs_in;

   // Decode the write beat; drop writes beyond the register list
   always_comb begin
      regs_in = regs_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tss_pkg::REG_COMMON: regs_in[tss_pkg::REG_COMMON] = csr_data;
            tss_pkg::REG_DAY1:   regs_in[tss_pkg::REG_DAY1]   = csr_data;
            tss_pkg::REG_DAY2:   regs_in[tss_pkg::REG_DAY2]   = csr_data;
            tss_pkg::REG_BUSY1:  regs_in[tss_pkg::REG_BUSY1]  = csr_data;
            tss_pkg::REG_BUSY2:  regs_in[tss_pkg::REG_BUSY2]  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign cfg = regs_ff;

endmodule

// ----- hdl/tss_lamp.sv -----
// Lamp pattern decoder: phase number to the four approach lamp groups.
module tss_lamp (
   input  logic [tss_pkg::PHASE_W-1:0] phase,
   output tss_pkg::lamps_type          lamps
);

   // Look up the pattern; phases past the table show all red
   always_comb begin
      if (phase < tss_pkg::PHASE_W'(tss_pkg::NUM_PHASES)) begin
         lamps = tss_pkg::LAMP_TABLE[phase];
      end else begin
         lamps = tss_pkg::LAMPS_ALL_RED;
      end
   end

endmodule

// ----- hdl/tss_ctrl.sv -----
// Phase sequencer: demand flags, tick countdown and per-mode next phase.
module tss_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  tss_pkg::tick_type  tick,
   input  tss_pkg::cfg_type   cfg,
   output tss_pkg::status_type status
);

   logic [tss_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [tss_pkg::TICKS_W-1:0] ticks_ff, ticks_in;
   logic                        north_ff, north_in;
   logic                        south_ff, south_in;

   logic                        north_set, south_set;
   logic                        north_take, south_take;
   logic                        expire;
   logic [tss_pkg::PHASE_W-1:0] next_phase;
   tss_pkg::dur_sel_type        dur_sel;
   logic [tss_pkg::TICKS_W-1:0] dur_raw;
   logic [tss_pkg::TICKS_W-1:0] dur;

   // Pick the next phase from the mode sequence
   always_comb begin
      north_set  = north_ff | tick.north;
      south_set  = south_ff | tick.south;
      north_take = 1'b0;
      south_take = 1'b0;
      next_phase = tss_pkg::PH_EMERGENCY;
      unique case (tick.mode)
         tss_pkg::MODE_DAY: begin
            if (phase_ff == tss_pkg::PH_DAY_CLEAR_NS) begin
               if (north_set) begin
                  north_take = 1'b1;
                  next_phase = tss_pkg::PH_NORTH_LEFT;
               end else if (south_set) begin
                  south_take = 1'b1;
                  next_phase = tss_pkg::PH_SOUTH_LEFT;
               end else begin
                  next_phase = tss_pkg::PH_WEST_GREEN;
               end
            end else if (phase_ff == tss_pkg::PH_DAY_CLEAR_NL) begin
               if (south_set) begin
                  south_take = 1'b1;
                  next_phase = tss_pkg::PH_SOUTH_LEFT;
               end else begin
                  next_phase = tss_pkg::PH_WEST_GREEN;
               end
            end else if (phase_ff == tss_pkg::PH_DAY_CLEAR_SL) begin
               next_phase = tss_pkg::PH_WEST_GREEN;
            end else if (phase_ff <= tss_pkg::PH_DAY_LAST) begin
               next_phase = phase_ff + tss_pkg::PHASE_W'(1);
            end else begin
               next_phase = tss_pkg::PH_NS_GREEN;
            end
         end
         tss_pkg::MODE_BUSY: begin
            if (phase_ff == tss_pkg::PH_NORTH_SOLO) begin
               if (south_set) begin
                  south_take = 1'b1;
                  next_phase = tss_pkg::PH_SOUTH_LEFT_BUSY;
               end else begin
                  next_phase = tss_pkg::PH_BOTH_GREEN;
               end
            end else if (phase_ff == tss_pkg::PH_BOTH_GREEN) begin
               if (north_set) begin
                  north_take = 1'b1;
                  next_phase = tss_pkg::PH_NORTH_LEFT_BUSY;
               end else begin
                  next_phase = tss_pkg::PH_BOTH_YELLOW;
               end
            end else if (phase_ff >= tss_pkg::PH_BUSY_START &&
                         phase_ff <  tss_pkg::PH_BUSY_LAST) begin
               next_phase = phase_ff + tss_pkg::PHASE_W'(1);
            end else begin
               next_phase = tss_pkg::PH_BUSY_START;
            end
         end
         tss_pkg::MODE_FLASH: begin
            next_phase = (phase_ff == tss_pkg::PH_FLASH_ON) ?
                         tss_pkg::PH_FLASH_OFF : tss_pkg::PH_FLASH_ON;
         end
         tss_pkg::MODE_EMERG: begin
            next_phase = tss_pkg::PH_EMERGENCY;
         end
         default: ;
      endcase
   end

   // Fetch the duration of the next phase; zero counts as one tick
   always_comb begin
      if (next_phase < tss_pkg::PHASE_W'(tss_pkg::NUM_PHASES)) begin
         dur_sel = tss_pkg::DUR_TABLE[next_phase];
      end else begin
         dur_sel = tss_pkg::DUR_ALL_RED;
      end
      dur_raw = cfg[dur_sel.reg_idx][tss_pkg::TICKS_W * dur_sel.slot +: tss_pkg::TICKS_W];
      dur     = (dur_raw == '0) ? tss_pkg::TICKS_W'(1) : dur_raw;
   end

   // Count down, or move on when the count runs out
   always_comb begin
      expire = (ticks_ff <= tss_pkg::TICKS_W'(1));
      if (expire) begin
         phase_in = next_phase;
         ticks_in = dur;
      end else begin
         phase_in = phase_ff;
         ticks_in = ticks_ff - tss_pkg::TICKS_W'(1);
      end
      north_in       = north_set & ~(expire & north_take);
      south_in       = south_set & ~(expire & south_take);
      status.phase   = phase_in;
      status.changed = (phase_in != phase_ff);
   end

   // Hold state between ticks
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tss_pkg::PH_RESET;
         ticks_ff <= tss_pkg::TICKS_W'(1);
         north_ff <= 1'b0;
         south_ff <= 1'b0;
      end else if (tick.valid) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         north_ff <= north_in;
         south_ff <= south_in;
      end
   end

endmodule

// ----- hdl/traffic_signal_sequencer.sv -----
// Traffic signal sequencer top level: input register, sequencer, result register.
// A request beat passes through the tick register and then the result register to show as a response beat.
// Throughput: one tick per cycle; the tick register and the result register each
// move whenever the stage behind them is free or being drained.
// Reset (synchronous, active high): phase 18, count 1, demands cleared, all timing
// registers zero, both stages empty.
module traffic_signal_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   // request: mode [1:0], north_sensor [2], south_sensor [3], zero [7:4]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tss_pkg::IN_W-1:0]        req_tdata,
   // response: phase [5:0], north_lamps [12:6], south_lamps [22:13],
   // west_lamps [29:23], east_lamps [35:30], phase_changed [36], zero [39:37]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tss_pkg::OUT_W-1:0]       rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tss_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic                        tick_valid_ff, tick_valid_in;
   logic [1:0]                  tick_mode_ff;
   logic                        tick_north_ff, tick_south_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tss_pkg::OUT_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                        out_free;
   logic                        advance;
   tss_pkg::tick_type           tick;
   tss_pkg::cfg_type            cfg;
   tss_pkg::status_type         status;
   tss_pkg::lamps_type          lamps;

   assign csr_ready = 1'b1;

   // Stage handshake: the result register frees the tick register
   assign out_free      = ~rsp_valid_ff | rsp_tready;
   assign advance       = tick_valid_ff & out_free;
   assign req_tready    = ~tick_valid_ff | out_free;
   assign tick_valid_in = req_tready ? req_tvalid : tick_valid_ff;
   assign rsp_valid_in  = out_free ? tick_valid_ff : rsp_valid_ff;

   assign tick.valid = advance;
   assign tick.mode  = tss_pkg::mode_type'(tick_mode_ff);
   assign tick.north = tick_north_ff;
   assign tick.south = tick_south_ff;

   tss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tss_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .tick   (tick),
      .cfg    (cfg),
      .status (status)
   );

   tss_lamp u_lamp (
      .phase (status.phase),
      .lamps (lamps)
   );

   // Pack the response beat
   assign rsp_data_in = {3'b000, status.changed, lamps.east, lamps.west,
                         lamps.south, lamps.north, status.phase};

   // Hold stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tick_valid_ff <= tick_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         tick_mode_ff  <= req_tdata[1:0];
         tick_north_ff <= req_tdata[2];
         tick_south_ff <= req_tdata[3];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hdl/tss_checker.sv -----
// Port-level checker of the traffic signal sequencer and its bind.
`include "traffic_signal_sequencer_macros.svh"

module tss_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [tss_pkg::OUT_W-1:0] rsp_tdata
);

   logic phase_ok;
   logic flash_off_dark;

   // Phase stays inside the numbered range
   assign phase_ok = rsp_tdata[5:0] < tss_pkg::PHASE_W'(tss_pkg::NUM_PHASES);
   // Flash-off phase turns every lamp off
   assign flash_off_dark = (rsp_tdata[5:0] != tss_pkg::PH_FLASH_OFF) ||
                           (rsp_tdata[35:6] == '0);

   `TSS_ASSERT(a_phase_range, clock, reset, (rsp_tvalid |-> phase_ok), "phase out of range")
   `TSS_ASSERT(a_flash_off, clock, reset, (rsp_tvalid |-> flash_off_dark), "flash off lamps lit")
   `TSS_ASSERT(a_stall_hold, clock, reset, (rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)), "stalled beat changed")
   `TSS_ASSERT_ALWAYS(a_reset_empty, clock, (reset |=> !rsp_tvalid), "response after reset")

endmodule

bind traffic_signal_sequencer tss_checker u_tss_checker (.*);

// ----- tb/tb_traffic_signal_sequencer.sv -----
// Self-checking testbench for the traffic signal sequencer with a built-in phase predictor.
module tb_traffic_signal_sequencer;
   import tss_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;
   localparam int LONG_HOLD    = 80;

   // One response beat as the predictor sees it
   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [6:0]         north;
      logic [9:0]         south;
      logic [6:0]         west;
      logic [5:0]         east;
      logic               changed;
   } signal_view_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_W-1:0]       req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_W-1:0]      rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   // Predictor state
   logic [CSR_DATA_W-1:0] timing_regs [NUM_REGS] = '{default: '0};
   logic [PHASE_W-1:0]    phase_now       = PH_RESET;
   logic [TICKS_W-1:0]    ticks_remaining = 16'd1;
   logic                  north_demand    = 1'b0;
   logic                  south_demand    = 1'b0;
   signal_view_type       expected_signals [$];

   // Run control and bookkeeping
   int src_idle_max     = 16;
   int sink_idle_max    = 16;
   int sink_hold_cycles = 0;
   int cycle_count      = 0;
   int mismatch_count   = 0;
   int ticks_sent       = 0;
   int beats_checked    = 0;
   int phase_changes    = 0;
   int timing_settings  = 0;

   traffic_signal_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // mode [1:0], north_sensor [2], south_sensor [3], zero [7:4]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // phase, north, south, west, east lamps, phase_changed
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d ticks still pending", cycle_count,
                  expected_signals.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [TICKS_W-1:0] timing_slot(input logic [CSR_IDX_W-1:0] idx,
                                                       input logic [1:0] slot);
      return timing_regs[idx][16*slot +: 16];
   endfunction

   // Duration loaded on entry to a phase; zero counts as one tick
   function automatic logic [TICKS_W-1:0] phase_ticks(input logic [PHASE_W-1:0] p);
      logic [TICKS_W-1:0] d;
      case (p)
         PH_NS_GREEN:        d = timing_slot(REG_DAY1, 2'd0);
         PH_NORTH_LEFT:      d = timing_slot(REG_DAY1, 2'd1);
         PH_SOUTH_LEFT:      d = timing_slot(REG_DAY1, 2'd2);
         PH_WEST_GREEN:      d = timing_slot(REG_DAY1, 2'd3);
         6'd12:              d = timing_slot(REG_DAY2, 2'd0);
         6'd15:              d = timing_slot(REG_DAY2, 2'd1);
         PH_EMERGENCY:       d = timing_slot(REG_DAY2, 2'd2);
         PH_NORTH_SOLO:      d = timing_slot(REG_BUSY1, 2'd0);
         PH_SOUTH_LEFT_BUSY: d = timing_slot(REG_BUSY1, 2'd1);
         PH_BOTH_GREEN:      d = timing_slot(REG_BUSY1, 2'd2);
         PH_NORTH_LEFT_BUSY: d = timing_slot(REG_BUSY1, 2'd3);
         6'd26:              d = timing_slot(REG_BUSY2, 2'd0);
         6'd29:              d = timing_slot(REG_BUSY2, 2'd1);
         6'd32:              d = timing_slot(REG_BUSY2, 2'd2);
         6'd1, 6'd4, 6'd7, 6'd10, 6'd13, 6'd16, PH_BOTH_YELLOW, 6'd27, 6'd30, 6'd33:
            d = timing_slot(REG_COMMON, SLOT_YELLOW);
         PH_FLASH_ON:        d = timing_slot(REG_COMMON, SLOT_FLASH_ON);
         PH_FLASH_OFF:       d = timing_slot(REG_COMMON, SLOT_FLASH_OFF);
         default:            d = timing_slot(REG_COMMON, SLOT_ALL_RED);
      endcase
      return (d == '0) ? 16'd1 : d;
   endfunction

   // Pick the phase that follows an expired one; consume left-turn demands taken
   function automatic logic [PHASE_W-1:0] following_phase(input logic [PHASE_W-1:0] p,
                                                          input mode_type m);
      logic [PHASE_W-1:0] nxt;
      case (m)
         MODE_DAY: begin
            if (p == PH_DAY_CLEAR_NS) begin
               if (north_demand) begin
                  north_demand = 1'b0;
                  nxt = PH_NORTH_LEFT;
               end else if (south_demand) begin
                  south_demand = 1'b0;
                  nxt = PH_SOUTH_LEFT;
               end else begin
                  nxt = PH_WEST_GREEN;
               end
            end else if (p == PH_DAY_CLEAR_NL) begin
               if (south_demand) begin
                  south_demand = 1'b0;
                  nxt = PH_SOUTH_LEFT;
               end else begin
                  nxt = PH_WEST_GREEN;
               end
            end else if (p == PH_DAY_CLEAR_SL) begin
               nxt = PH_WEST_GREEN;
            end else if (p <= PH_DAY_LAST) begin
               nxt = p + 6'd1;
            end else begin
               nxt = PH_NS_GREEN;
            end
         end
         MODE_BUSY: begin
            if (p == PH_NORTH_SOLO) begin
               if (south_demand) begin
                  south_demand = 1'b0;
                  nxt = PH_SOUTH_LEFT_BUSY;
               end else begin
                  nxt = PH_BOTH_GREEN;
               end
            end else if (p == PH_BOTH_GREEN) begin
               if (north_demand) begin
                  north_demand = 1'b0;
                  nxt = PH_NORTH_LEFT_BUSY;
               end else begin
                  nxt = PH_BOTH_YELLOW;
               end
            end else if (p == PH_BUSY_LAST) begin
               nxt = PH_BUSY_START;
            end else if (p >= PH_BUSY_START && p < PH_BUSY_LAST) begin
               nxt = p + 6'd1;
            end else begin
               nxt = PH_BUSY_START;
            end
         end
         MODE_FLASH: nxt = (p == PH_FLASH_ON) ? PH_FLASH_OFF : PH_FLASH_ON;
         default:    nxt = PH_EMERGENCY;
      endcase
      return nxt;
   endfunction

   // Lamp pattern shown in a phase; unlisted phases show all red
   function automatic lamps_type lamp_pattern(input logic [PHASE_W-1:0] p);
      lamps_type l;
      l = '{AR_N, AR_S, AR_W, AR_E};
      case (p)
         0, 22:  begin l.north = 7'd36; l.south = 10'd292; end
         1, 24:  begin l.north = 7'd18; l.south = 10'd146; end
         3:      l.north = 7'd73;
         4:      l.north = 7'd10;
         6:      l.south = 10'd585;
         7:      l.south = 10'd74;
         9, 26:  l.west = 7'd36;
         10, 27: l.west = 7'd18;
         12, 29: l.east = 6'd36;
         13, 30: l.east = 6'd18;
         15, 32: l.west = 7'd65;
         16, 33: l.west = 7'd17;
         20:     l.north = 7'd36;
         21:     begin l.north = 7'd36; l.south = 10'd585; end
         23:     begin l.north = 7'd73; l.south = 10'd292; end
         38:     begin l.north = 7'd18; l.south = 10'd18; end
         39:     l = '0;
         default: ;
      endcase
      return l;
   endfunction

   // Advance the predicted intersection by one tick and queue the beat it shows
   task automatic predict_tick(input mode_type m, input logic n, input logic s);
      signal_view_type want;
      lamps_type       lamps;
      logic [PHASE_W-1:0] prior;
      if (n) north_demand = 1'b1;
      if (s) south_demand = 1'b1;
      prior = phase_now;
      if (ticks_remaining <= 16'd1) begin
         phase_now = following_phase(phase_now, m);
         ticks_remaining = phase_ticks(phase_now);
      end else begin
         ticks_remaining = ticks_remaining - 16'd1;
      end
      lamps = lamp_pattern(phase_now);
      want.phase   = phase_now;
      want.north   = lamps.north;
      want.south   = lamps.south;
      want.west    = lamps.west;
      want.east    = lamps.east;
      want.changed = (phase_now != prior);
      expected_signals.push_back(want);
   endtask

   // ---------------------------------------------------------------- drivers

   // Offer one tick, hold until accepted, then idle a random number of cycles
   task automatic send_tick(input mode_type m, input logic n, input logic s);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, s, n, m};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_tick(m, n, s);
      ticks_sent++;
      gap = $urandom_range(0, src_idle_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Write one timing register; csr_valid stays high for a following write
   task automatic write_timing(input logic [CSR_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx < NUM_REGS) timing_regs[idx] = value;
   endtask

   // Stop offering ticks and wait until every predicted beat has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_signals.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Load all registers with small random durations; unused slots get any value
   task automatic program_timing(input int max_ticks);
      logic [CSR_DATA_W-1:0] value;
      wait_for_results();
      for (int r = 0; r < NUM_REGS; r++) begin
         for (int k = 0; k < 4; k++) value[16*k +: 16] = 16'($urandom_range(0, max_ticks));
         if (r == REG_DAY2 || r == REG_BUSY2) value[63:48] = 16'($urandom);
         write_timing(CSR_IDX_W'(r), value);
      end
      // a write past the last register must change nothing
      write_timing(CSR_IDX_W'($urandom_range(NUM_REGS, 7)), '1);
      csr_valid <= 1'b0;
      timing_settings++;
   endtask

   // Random traffic: mostly runs of one mode so sequences progress, with stray ticks
   task automatic run_random_ticks(input int count);
      mode_type run_mode;
      int       run_left;
      int       pick;
      run_mode = MODE_DAY;
      run_left = 0;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            pick = $urandom_range(0, 99);
            run_mode = (pick < 40) ? MODE_DAY : (pick < 75) ? MODE_BUSY :
                       (pick < 90) ? MODE_FLASH : MODE_EMERG;
            run_left = $urandom_range(1, 60);
         end
         run_left--;
         if ($urandom_range(0, 11) == 0)
            send_tick(mode_type'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
         else
            send_tick(run_mode, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      end
   endtask

   // ---------------------------------------------------------------- response side

   // Hold off after each beat; a requested long hold takes priority
   initial begin : sink_ready
      int wait_n;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         wait_n = 0;
         if (sink_hold_cycles > 0) begin
            wait_n = sink_hold_cycles;
            sink_hold_cycles = 0;
         end else if (rsp_tvalid && rsp_tready) begin
            wait_n = $urandom_range(0, sink_idle_max);
         end
         if (wait_n > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_n) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each response beat with the oldest prediction
   always @(posedge clock) begin : check_beats
      signal_view_type seen;
      signal_view_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.phase   = rsp_tdata[5:0];
         seen.north   = rsp_tdata[12:6];
         seen.south   = rsp_tdata[22:13];
         seen.west    = rsp_tdata[29:23];
         seen.east    = rsp_tdata[35:30];
         seen.changed = rsp_tdata[36];
         beats_checked++;
         if (seen.changed) phase_changes++;
         if (expected_signals.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("beat %0d arrived with no tick pending: phase %0d", beats_checked,
                        seen.phase);
         end else begin
            want = expected_signals.pop_front();
            if (seen.phase !== want.phase || seen.north !== want.north ||
                seen.south !== want.south || seen.west !== want.west ||
                seen.east !== want.east || seen.changed !== want.changed) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"beat %0d mismatch: expected phase %0d N=%h S=%h W=%h E=%h chg=%b,",
                            " got phase %0d N=%h S=%h W=%h E=%h chg=%b"},
                           beats_checked, want.phase, want.north, want.south, want.west,
                           want.east, want.changed, seen.phase, seen.north, seen.south,
                           seen.west, seen.east, seen.changed);
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // Reset timing is all zero, so every phase lasts one tick: walk each sequence
   task automatic test_zero_timing_sequences();
      send_tick(MODE_DAY, 1'b0, 1'b0);     // reset phase to NS green
      send_tick(MODE_DAY, 1'b0, 1'b0);
      send_tick(MODE_DAY, 1'b1, 1'b1);     // raise both left-turn demands
      send_tick(MODE_DAY, 1'b0, 1'b0);     // north left taken
      send_tick(MODE_DAY, 1'b0, 1'b0);
      send_tick(MODE_DAY, 1'b0, 1'b0);
      send_tick(MODE_DAY, 1'b0, 1'b0);     // south left taken
      send_tick(MODE_DAY, 1'b0, 1'b0);
      send_tick(MODE_BUSY, 1'b0, 1'b1);    // day phase under high traffic restarts busy cycle
      send_tick(MODE_BUSY, 1'b0, 1'b0);
      send_tick(MODE_BUSY, 1'b1, 1'b0);    // south left during north solo
      send_tick(MODE_BUSY, 1'b0, 1'b0);
      send_tick(MODE_BUSY, 1'b0, 1'b0);    // north left during south
      send_tick(MODE_BUSY, 1'b0, 1'b0);
      send_tick(MODE_FLASH, 1'b0, 1'b0);   // into the flash pair
      send_tick(MODE_FLASH, 1'b0, 1'b0);
      send_tick(MODE_FLASH, 1'b0, 1'b0);
      send_tick(MODE_EMERG, 1'b0, 1'b0);
      send_tick(MODE_EMERG, 1'b1, 1'b1);   // hold reloads without a phase change
      send_tick(MODE_DAY, 1'b0, 1'b0);     // emergency phase under daytime goes to NS green
      wait_for_results();
   endtask

   // All-ones registers kept away from the phases in use, then all-ones common times
   task automatic test_register_extremes();
      wait_for_results();
      write_timing(REG_COMMON, {16'd2, 16'd3, 16'd2, 16'd1});
      write_timing(REG_DAY1, '1);
      write_timing(REG_DAY2, '1);
      write_timing(REG_BUSY1, '1);
      write_timing(REG_BUSY2, '1);
      for (int idx = NUM_REGS; idx < 8; idx++) write_timing(CSR_IDX_W'(idx), '1);
      csr_valid <= 1'b0;
      timing_settings++;
      repeat (4) send_tick(MODE_FLASH, 1'($urandom), 1'($urandom));
      wait_for_results();
      write_timing(REG_DAY2, {16'hFFFF, 16'd2, 16'hFFFF, 16'hFFFF});
      write_timing(REG_COMMON, '1);
      csr_valid <= 1'b0;
      timing_settings++;
      repeat (7) send_tick(MODE_EMERG, 1'($urandom), 1'($urandom));
      wait_for_results();
   endtask

   // Long random runs under several timing settings and idling mixes
   task automatic test_random_traffic();
      program_timing(3);
      src_idle_max  = 16;
      sink_idle_max = 16;
      run_random_ticks(110);
      program_timing(0);
      src_idle_max  = 0;
      sink_idle_max = 16;
      run_random_ticks(100);
      program_timing(8);
      src_idle_max  = 16;
      sink_idle_max = 0;
      run_random_ticks(110);
      program_timing(12);
      src_idle_max  = 0;
      sink_idle_max = 0;
      run_random_ticks(100);
   endtask

   // Hold the response side off while ticks keep coming so the input stalls
   task automatic test_output_backpressure();
      program_timing(3);
      src_idle_max     = 0;
      sink_idle_max    = 0;
      sink_hold_cycles = LONG_HOLD;
      run_random_ticks(40);
      wait_for_results();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_zero_timing_sequences();
      test_register_extremes();
      test_random_traffic();
      test_output_backpressure();
      wait_for_results();
      repeat (8) @(posedge clock);
      $display("Ran %0d ticks in all four modes under %0d timing settings, %0d beats checked.",
               ticks_sent, timing_settings, beats_checked);
      $display("Saw %0d phase changes; %0d mismatches.", phase_changes, mismatch_count);
      if (mismatch_count == 0 && expected_signals.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/tss_pkg.sv
hdl/tss_csr.sv
hdl/tss_lamp.sv
hdl/tss_ctrl.sv
hdl/traffic_signal_sequencer.sv
hdl/tss_checker.sv
tb/tb_traffic_signal_sequencer.sv
